[hdl/iira_pkg.sv]
`default_nettype none

package iira_pkg;

    // Field widths fixed by the item format
    localparam int DATA_W = 32;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 5;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    // Default number of stored elements
    localparam int DEF_CAPACITY = 16;

    // Position width: covers counts up to the largest supported capacity (1024)
    localparam int POS_W = 11;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_GET     = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_REPLACE = 3'd4,
        OP_LENGTH  = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic             capture;  // latch the incoming value
        logic             ins;      // open a gap at pos and write value
        logic             rem;      // close the gap at pos
        logic             repl;     // overwrite the entry at pos
        logic             load;     // load the result register
        logic             rd_ok;    // result carries the entry at pos
        logic             rd_err;   // result carries all ones
        status_t          status;
        logic [POS_W-1:0] pos;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [POS_W-1:0] count;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/iira_if.sv]
`default_nettype none

// Request channel: one operation per transfer
interface iira_req_if;
    logic                               valid;
    logic                               ready;
    logic [iira_pkg::OP_W-1:0]          op;
    logic [iira_pkg::IDX_W-1:0]         index;
    logic signed [iira_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

// Response channel: one result per request
interface iira_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [iira_pkg::DATA_W-1:0] read_value;
    logic [iira_pkg::ST_W-1:0]          status;
    logic [iira_pkg::CNT_W-1:0]         element_count;

    modport source (output valid, output read_value, output status, output element_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input element_count,
                    output ready);
endinterface

`default_nettype wire

[hdl/indexed_insert_remove_array_top.sv]
// Indexed insert/remove array: an ordered store of up to CAPACITY signed
// 32-bit elements kept in a chain of cells.
// req channel: op, index, value; one operation per transfer.
// rsp channel: read_value, status, element_count; exactly one result per
// request, in request order.
// Timing: a request is taken and then executed once the result slot is
// free, where every cell shifts, loads or holds at once; the result is
// registered and shown together with rsp.valid. A new request is taken
// only after the previous one has executed, set by the latch-then-execute
// sequencer.
// The result register decouples the channels: a new request is taken while
// an earlier result waits. If rsp stalls, execution of the next request
// holds until the pending result is transferred, and req.ready stays low
// meanwhile.
// Reset (rst_n, asynchronous, active low) empties the store and drops
// rsp.valid; cell contents are not cleared and are read only once written.
`default_nettype none

module indexed_insert_remove_array_top #(
    parameter int CAPACITY = iira_pkg::DEF_CAPACITY
) (
    input  wire logic clk,
    input  wire logic rst_n,
    iira_req_if.sink  req,
    iira_rsp_if.source rsp
);

    iira_pkg::dp_cmd_t  cmd;
    iira_pkg::dp_stat_t stat;

    iira_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_index (req.index),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    iira_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .value         (req.value),
        .stat          (stat),
        .read_value    (rsp.read_value),
        .status        (rsp.status),
        .element_count (rsp.element_count)
    );

endmodule

`default_nettype wire

[hdl/iira_datapath.sv]
`default_nettype none

module iira_datapath #(
    parameter int CAPACITY = iira_pkg::DEF_CAPACITY
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire iira_pkg::dp_cmd_t                  cmd,
    input  wire logic signed [iira_pkg::DATA_W-1:0] value,
    output iira_pkg::dp_stat_t                      stat,
    output logic signed [iira_pkg::DATA_W-1:0]      read_value,
    output logic [iira_pkg::ST_W-1:0]               status,
    output logic [iira_pkg::CNT_W-1:0]              element_count
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int RDN = (CAPACITY < 32) ? CAPACITY : 32;

    logic signed [iira_pkg::DATA_W-1:0] cells_reg [CAPACITY];
    logic signed [iira_pkg::DATA_W-1:0] value_reg;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic signed [iira_pkg::DATA_W-1:0] rd_data;
    logic signed [iira_pkg::DATA_W-1:0] read_value_reg;
    logic [iira_pkg::ST_W-1:0]          status_reg;
    logic [iira_pkg::CNT_W-1:0]         element_count_reg;

    assign stat.count = iira_pkg::POS_W'(count_reg);

    // Held operand
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= value;
        end
    end

    // Cell chain: every cell shifts, loads or holds in the same cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cmd.ins)
            begin
                if (iira_pkg::POS_W'(i) == cmd.pos)
                begin
                    cells_reg[i] <= value_reg;
                end
                else if ((iira_pkg::POS_W'(i) > cmd.pos) && (i > 0))
                begin
                    cells_reg[i] <= cells_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.rem)
            begin
                if ((iira_pkg::POS_W'(i) >= cmd.pos) && (i < CAPACITY - 1))
                begin
                    cells_reg[i] <= cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
            else if (cmd.repl)
            begin
                if (iira_pkg::POS_W'(i) == cmd.pos)
                begin
                    cells_reg[i] <= value_reg;
                end
            end
        end
    end

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Read select over the addressable cells
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < RDN; i++)
        begin
            if (cmd.pos == iira_pkg::POS_W'(i))
            begin
                rd_data = cells_reg[i];
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cmd.rd_ok)
            begin
                read_value_reg <= rd_data;
            end
            else if (cmd.rd_err)
            begin
                read_value_reg <= '1;
            end
            else
            begin
                read_value_reg <= '0;
            end
            status_reg        <= cmd.status;
            element_count_reg <= iira_pkg::CNT_W'(count_next);
        end
    end

    assign read_value    = read_value_reg;
    assign status        = status_reg;
    assign element_count = element_count_reg;

endmodule

`default_nettype wire

[hdl/iira_ctrl.sv]
`default_nettype none

module iira_ctrl #(
    parameter int CAPACITY = iira_pkg::DEF_CAPACITY
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire logic [iira_pkg::OP_W-1:0]  req_op,
    input  wire logic [iira_pkg::IDX_W-1:0] req_index,
    output logic                            req_ready,
    output logic                            rsp_valid,
    input  wire logic                       rsp_ready,
    input  wire iira_pkg::dp_stat_t         stat,
    output iira_pkg::dp_cmd_t               cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    localparam logic [iira_pkg::POS_W-1:0] CAP = iira_pkg::POS_W'(CAPACITY);

    state_t                     state_reg;
    state_t                     state_next;
    logic [iira_pkg::OP_W-1:0]  op_reg;
    logic [iira_pkg::IDX_W-1:0] index_reg;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    logic                       req_xfer;
    logic                       go;
    logic [iira_pkg::POS_W-1:0] idx_ext;
    logic                       full;
    logic                       idx_in_use;
    logic                       idx_past_end;

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    // Result slot is free or drains this cycle
    assign go = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    assign idx_ext      = iira_pkg::POS_W'(index_reg);
    assign full         = (stat.count >= CAP);
    assign idx_in_use   = (idx_ext < stat.count);
    assign idx_past_end = (idx_ext > stat.count);

    // Operation latch
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg    <= req_op;
            index_reg <= req_index;
        end
    end

    // Decode of the held operation against the current fill count
    always_comb
    begin
        cmd         = '0;
        cmd.status  = iira_pkg::ST_OK;
        cmd.capture = req_xfer;
        cmd.pos     = idx_ext;
        cmd.load    = go;
        case (op_reg)
            iira_pkg::OP_APPEND:
            begin
                cmd.pos = stat.count;
                if (full)
                begin
                    cmd.status = iira_pkg::ST_FULL;
                end
                else
                begin
                    cmd.ins = go;
                end
            end
            iira_pkg::OP_INSERT:
            begin
                if (idx_past_end)
                begin
                    cmd.status = iira_pkg::ST_RANGE;
                end
                else if (full)
                begin
                    cmd.status = iira_pkg::ST_FULL;
                end
                else
                begin
                    cmd.ins = go;
                end
            end
            iira_pkg::OP_GET:
            begin
                if (idx_in_use)
                begin
                    cmd.rd_ok = 1'b1;
                end
                else
                begin
                    cmd.status = iira_pkg::ST_RANGE;
                    cmd.rd_err = 1'b1;
                end
            end
            iira_pkg::OP_REMOVE:
            begin
                if (idx_in_use)
                begin
                    cmd.rem = go;
                end
                else
                begin
                    cmd.status = iira_pkg::ST_RANGE;
                end
            end
            iira_pkg::OP_REPLACE:
            begin
                if (idx_in_use)
                begin
                    cmd.repl = go;
                end
                else
                begin
                    cmd.status = iira_pkg::ST_RANGE;
                end
            end
            default:
            begin
                // read length and unused codes change nothing
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (go)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire
